// ===== rtl/core/tgcs_pkg.sv =====
// Shared types, command codes and the 5x7 font table for the glyph command stream.
// No dependencies; every module of the block imports this package.
package tgcs_pkg;

  localparam int CoordW   = 16;
  localparam int ColorW   = 16;
  localparam int WidthW   = 9;
  localparam int GlyphCols = 5;
  localparam int GlyphRows = 7;
  localparam int GlyphCount = 95;

  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;

  localparam logic ACT_SET_CURSOR = 1'b0;
  localparam logic ACT_DRAW       = 1'b1;

  localparam logic [WidthW-1:0] WIDTH_RESET = 9'd320;

  typedef struct packed {
    logic              action;
    logic [7:0]        char_code;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [ColorW-1:0] fg_color;
    logic [ColorW-1:0] bg_color;
  } item_t;

  typedef struct packed {
    logic [15:0] word;
    logic        is_data;
    logic        last;
  } cmd_t;

  typedef logic [GlyphCols-1:0][GlyphRows-1:0] glyph_t;

  // One queued draw request: window origin, glyph bitmap and colors.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    glyph_t            glyph;
    logic [ColorW-1:0] fg;
    logic [ColorW-1:0] bg;
  } draw_req_t;

  // Column bytes, leftmost column in the top byte, bit 0 the top row.
  localparam logic [0:GlyphCount-1][39:0] FONT_ROM = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
    40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h08082A1C08
  };

  function automatic glyph_t font_glyph(input logic [6:0] idx);
    logic [39:0] row;
    glyph_t      g;
    row = FONT_ROM[idx];
    // take bits 6..0 of each column byte; bit 7 is never drawn
    for (int c = 0; c < GlyphCols; c++) begin
      g[c] = row[38 - 8*c -: GlyphRows];
    end
    return g;
  endfunction

endpackage

// ===== rtl/core/text_glyph_command_stream.sv =====
// Top level of the 5x7 glyph command stream generator.
// Depends on tgcs_pkg, tgcs_front, tgcs_queue and tgcs_back.
//
// A draw request emits 55 words (column-set, x0, x1, row-set, y0, y1, memory-write,
// then 48 pixels of a 6x8 cell, row by row) at one word per clock while cmd_stall is
// low, through a single-word output register. Set-cursor requests produce no words.
// The front end takes a request every cycle until the queue holds QUEUE_DEPTH draws,
// the one being emitted included, so with QUEUE_DEPTH above 1 and the next draw queued,
// draws stream back to back with no gap on the output. Cursor moves and line wrap apply
// in request order at acceptance.
module text_glyph_command_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tgcs_pkg::WidthW-1:0]  cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  tgcs_pkg::item_t              item,
  output logic                         cmd_valid,
  input  logic                         cmd_stall,
  output tgcs_pkg::cmd_t               cmd
);
  import tgcs_pkg::*;

  logic      accept;
  logic      push;
  draw_req_t push_data;
  draw_req_t head;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  tgcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .push_data (push_data)
  );

  tgcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tgcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd)
  );

endmodule

// ===== rtl/core/tgcs_front.sv =====
// Front end: accepts requests, keeps the text cursor and width register, looks up the glyph.
// Depends on tgcs_pkg; pushes draw requests into tgcs_queue.
module tgcs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tgcs_pkg::WidthW-1:0]  cfg_data,
  input  logic                         accept,
  input  tgcs_pkg::item_t              item,
  output logic                         push,
  output tgcs_pkg::draw_req_t          push_data
);
  import tgcs_pkg::*;

  logic [WidthW-1:0] display_width;
  logic [CoordW-1:0] cursor_col;
  logic [CoordW-1:0] cursor_row;
  logic [CoordW-1:0] cursor_col_next;
  logic [CoordW-1:0] cursor_row_next;
  logic [CoordW-1:0] col_step;
  logic              wrap;
  logic [6:0]        glyph_idx;
  logic              printable;

  assign printable = (item.char_code >= FIRST_CODE) && (item.char_code <= LAST_CODE);
  assign glyph_idx = printable ? 7'(item.char_code - FIRST_CODE) : 7'd0;

  assign col_step = cursor_col + CoordW'(6);
  assign wrap     = ({1'b0, col_step} + 17'd6) > {8'd0, display_width};

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (accept) begin
      if (item.action == ACT_SET_CURSOR) begin
        cursor_col_next = item.pos_x;
        cursor_row_next = item.pos_y;
      end else if (wrap) begin
        cursor_col_next = '0;
        cursor_row_next = cursor_row + CoordW'(8);
      end else begin
        cursor_col_next = col_step;
      end
    end
  end

  assign push            = accept && (item.action == ACT_DRAW);
  assign push_data.x     = cursor_col;
  assign push_data.y     = cursor_row;
  assign push_data.glyph = font_glyph(glyph_idx);
  assign push_data.fg    = item.fg_color;
  assign push_data.bg    = item.bg_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width <= WIDTH_RESET;
      cursor_col    <= '0;
      cursor_row    <= '0;
    end else begin
      if (cfg_we) begin
        display_width <= cfg_data;
      end
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

// ===== rtl/core/tgcs_queue.sv =====
// Short FIFO of draw requests between the front end and the sequencer.
// Depends on tgcs_pkg for the entry type.
module tgcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tgcs_pkg::draw_req_t push_data,
  input  logic                pop,
  output tgcs_pkg::draw_req_t head,
  output logic                full,
  output logic                empty
);
  import tgcs_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  draw_req_t       entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tgcs_back.sv =====
// Back end: walks one queued draw request and emits its 55-word command stream.
// Depends on tgcs_pkg; reads the head of tgcs_queue and drives the output register.
module tgcs_back (
  input  logic                clk,
  input  logic                rst,
  input  tgcs_pkg::draw_req_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                cmd_valid,
  input  logic                cmd_stall,
  output tgcs_pkg::cmd_t      cmd
);
  import tgcs_pkg::*;

  typedef enum logic [1:0] {
    ST_HEAD  = 2'b01,
    ST_PIXEL = 2'b10
  } back_state_t;

  localparam logic [2:0] HDR_COLSET = 3'd0;
  localparam logic [2:0] HDR_X0     = 3'd1;
  localparam logic [2:0] HDR_X1     = 3'd2;
  localparam logic [2:0] HDR_ROWSET = 3'd3;
  localparam logic [2:0] HDR_Y0     = 3'd4;
  localparam logic [2:0] HDR_Y1     = 3'd5;
  localparam logic [2:0] HDR_MEMWR  = 3'd6;
  localparam logic [2:0] CellLastCol = 3'd5;
  localparam logic [2:0] CellLastRow = 3'd7;

  back_state_t state;
  back_state_t state_next;
  logic [2:0]  hdr_idx;
  logic [2:0]  hdr_idx_next;
  logic [2:0]  pix_col;
  logic [2:0]  pix_col_next;
  logic [2:0]  pix_row;
  logic [2:0]  pix_row_next;
  logic        advance;
  logic        lit;
  cmd_t        word_next;

  // Load the output register when a request is waiting and the register is empty or being taken.
  assign advance = head_valid && (!cmd_valid || !cmd_stall);

  assign lit = (pix_col < 3'(GlyphCols)) && (pix_row < 3'(GlyphRows))
               && head.glyph[pix_col[2:0] > 3'd4 ? 3'd0 : pix_col]
                            [pix_row > 3'd6 ? 3'd0 : pix_row];

  always_comb begin
    word_next    = '0;
    state_next   = state;
    hdr_idx_next = hdr_idx;
    pix_col_next = pix_col;
    pix_row_next = pix_row;
    pop          = 1'b0;
    unique case (state)
      ST_HEAD: begin
        hdr_idx_next = hdr_idx + 3'd1;
        unique case (hdr_idx)
          HDR_COLSET: word_next = '{word: {8'd0, CMD_COLSET}, is_data: 1'b0, last: 1'b0};
          HDR_X0:     word_next = '{word: head.x, is_data: 1'b1, last: 1'b0};
          HDR_X1:     word_next = '{word: head.x + 16'd5, is_data: 1'b1, last: 1'b0};
          HDR_ROWSET: word_next = '{word: {8'd0, CMD_ROWSET}, is_data: 1'b0, last: 1'b0};
          HDR_Y0:     word_next = '{word: head.y, is_data: 1'b1, last: 1'b0};
          HDR_Y1:     word_next = '{word: head.y + 16'd7, is_data: 1'b1, last: 1'b0};
          HDR_MEMWR: begin
            word_next    = '{word: {8'd0, CMD_MEMWR}, is_data: 1'b0, last: 1'b0};
            state_next   = ST_PIXEL;
            hdr_idx_next = HDR_COLSET;
          end
          default: begin
            hdr_idx_next = HDR_COLSET;
          end
        endcase
      end
      ST_PIXEL: begin
        word_next.word    = lit ? head.fg : head.bg;
        word_next.is_data = 1'b1;
        word_next.last    = (pix_col == CellLastCol) && (pix_row == CellLastRow);
        if (pix_col == CellLastCol) begin
          pix_col_next = '0;
          pix_row_next = pix_row + 3'd1;
          if (pix_row == CellLastRow) begin
            state_next = ST_HEAD;
            pop        = advance;
          end
        end else begin
          pix_col_next = pix_col + 3'd1;
        end
      end
      default: begin
        state_next = ST_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HEAD;
      hdr_idx   <= HDR_COLSET;
      pix_col   <= '0;
      pix_row   <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (advance) begin
        state   <= state_next;
        hdr_idx <= hdr_idx_next;
        pix_col <= pix_col_next;
        pix_row <= pix_row_next;
      end
      if (!cmd_valid || !cmd_stall) begin
        cmd_valid <= head_valid;
      end
    end
  end

endmodule
